// ===== src/assert_macros.svh =====
// Assertion macros for the ray-segment intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define RSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a clock edge out of reset.
`define RSI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RSI_ASSERT(lbl, prop, msg)
`define RSI_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/rsi_pkg.sv =====
// Shared constants and types of the ray-segment intersection block.
package rsi_pkg;

  localparam int COORD_WIDTH_DFLT = 32;
  localparam int DIST_W           = 31;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam int MUL_DIG          = 8;
  localparam int FIFO_DEPTH       = 2;
  localparam int REASON_W         = 3;

  typedef enum logic [REASON_W-1:0] {
    RSN_HIT      = 3'd0,
    RSN_PARALLEL = 3'd1,
    RSN_BEHIND   = 3'd2,
    RSN_OUTSIDE  = 3'd3,
    RSN_DEGEN    = 3'd4
  } reason_t;

endpackage

// ===== src/ray_segment_intersect.sv =====
// Ray against line segment intersection, top level.
// Throughput: one transaction per cycle; busy stays low in steady operation.
// Pipeline: 4 front stages, the queue, ceil((2*COORD_WIDTH+2)/8) square stages,
// ceil(2*COORD_WIDTH/8) product stages and 31 distance-bit stages.
// Reset: synchronous active-low rst_n clears all valid bits and the queue.
// Results appear for one cycle on out_valid; the receiver cannot stall.
module ray_segment_intersect
  import rsi_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_seg_ax,
  input  logic signed [COORD_WIDTH-1:0] in_seg_ay,
  input  logic signed [COORD_WIDTH-1:0] in_seg_bx,
  input  logic signed [COORD_WIDTH-1:0] in_seg_by,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [DIST_W-1:0]             out_distance,
  output logic [REASON_W-1:0]           out_miss_reason
);

  localparam int MW  = 2 * COORD_WIDTH + 2;
  localparam int NDW = 2 * COORD_WIDTH;
  localparam int QW  = REASON_W + 2 * MW + NDW;

  logic                 accept;
  logic                 fq_full;
  logic                 f_valid;
  reason_t              f_reason;
  logic [MW-1:0]        f_cs, f_cd;
  logic [NDW-1:0]       f_nd;

  assign busy   = fq_full;
  assign accept = start && !busy;

  rsi_front #(.CW(COORD_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .valid_i(accept),
    .start_x(in_start_x), .start_y(in_start_y), .dir_x(in_dir_x), .dir_y(in_dir_y),
    .seg_ax(in_seg_ax), .seg_ay(in_seg_ay), .seg_bx(in_seg_bx), .seg_by(in_seg_by),
    .valid_o(f_valid), .reason_o(f_reason), .cs_mag_o(f_cs), .cd_mag_o(f_cd),
    .nd_o(f_nd)
  );

  // queue between classification and the arithmetic back end
  logic          q_valid;
  logic [QW-1:0] q_data;

  rsi_fifo #(.WIDTH(QW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push_i(f_valid),
    .data_i({REASON_W'(f_reason), f_cs, f_cd, f_nd}),
    .pop_i(1'b1), .valid_o(q_valid), .data_o(q_data), .full_o(fq_full)
  );

  reason_t b_reason;

  rsi_back #(.CW(COORD_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .valid_i(q_valid),
    .reason_i(reason_t'(q_data[QW-1 -: REASON_W])),
    .cs_mag_i(q_data[2*MW+NDW-1 -: MW]),
    .cd_mag_i(q_data[MW+NDW-1 -: MW]),
    .nd_i(q_data[NDW-1:0]),
    .valid_o(out_valid), .hit_o(out_hit), .distance_o(out_distance),
    .reason_o(b_reason)
  );

  assign out_miss_reason = REASON_W'(b_reason);

endmodule

// ===== src/rsi_mul.sv =====
// Pipelined unsigned multiplier, one 8-bit digit of b per stage, with sideband.
module rsi_mul
  import rsi_pkg::*;
#(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [AW+BW-1:0] p_o,
  output logic [SW-1:0] side_o
);

  localparam int NST = (BW + MUL_DIG - 1) / MUL_DIG;
  localparam int BPW = NST * MUL_DIG;
  localparam int PW  = AW + BW;
  localparam int PPW = AW + MUL_DIG;

  logic [AW-1:0]  a_s    [NST];
  logic [BPW-1:0] b_s    [NST];
  logic [PW-1:0]  acc_s  [NST];
  logic [SW-1:0]  side_s [NST];
  logic           v_s    [NST];

  for (genvar j = 0; j < NST; j++) begin : g_stg
    logic [AW-1:0]  a_in;
    logic [BPW-1:0] b_in;
    logic [PW-1:0]  acc_in;
    logic [SW-1:0]  side_in;
    logic           v_in;
    logic [PPW-1:0] pp;

    if (j == 0) begin : g_first
      assign a_in    = a_i;
      assign b_in    = BPW'(b_i);
      assign acc_in  = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign a_in    = a_s[j-1];
      assign b_in    = b_s[j-1];
      assign acc_in  = acc_s[j-1];
      assign side_in = side_s[j-1];
      assign v_in    = v_s[j-1];
    end

    // one digit partial product
    assign pp = PPW'(a_in) * PPW'(b_in[MUL_DIG*j +: MUL_DIG]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s[j] <= 1'b0;
      end else begin
        v_s[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      a_s[j]    <= a_in;
      b_s[j]    <= b_in;
      side_s[j] <= side_in;
      acc_s[j]  <= acc_in + (PW'(pp) << (MUL_DIG * j));
    end
  end

  assign valid_o = v_s[NST-1];
  assign p_o     = acc_s[NST-1];
  assign side_o  = side_s[NST-1];

endmodule

// ===== src/rsi_front.sv =====
// Front end: differences, cross products and miss classification.
module rsi_front
  import rsi_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DFLT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] start_x,
  input  logic signed [CW-1:0] start_y,
  input  logic signed [CW-1:0] dir_x,
  input  logic signed [CW-1:0] dir_y,
  input  logic signed [CW-1:0] seg_ax,
  input  logic signed [CW-1:0] seg_ay,
  input  logic signed [CW-1:0] seg_bx,
  input  logic signed [CW-1:0] seg_by,
  output logic                 valid_o,
  output reason_t              reason_o,
  output logic [2*CW+1:0]      cs_mag_o,
  output logic [2*CW+1:0]      cd_mag_o,
  output logic [2*CW-1:0]      nd_o
);

  localparam int DW  = CW + 1;
  localparam int PRW = 2 * DW;
  localparam int XW  = PRW + 1;
  localparam int MW  = XW - 1;
  localparam int NDW = 2 * CW;

  // stage 1: differences against endpoint A
  logic signed [DW-1:0] sx_r, sy_r, lx_r, ly_r, dx_r, dy_r;
  logic                 dz1_r, lz1_r, v1_r;

  always_ff @(posedge clk) begin
    sx_r  <= DW'(start_x) - DW'(seg_ax);
    sy_r  <= DW'(start_y) - DW'(seg_ay);
    lx_r  <= DW'(seg_bx) - DW'(seg_ax);
    ly_r  <= DW'(seg_by) - DW'(seg_ay);
    dx_r  <= DW'(dir_x);
    dy_r  <= DW'(dir_y);
    dz1_r <= (dir_x == '0) && (dir_y == '0);
    lz1_r <= (seg_bx == seg_ax) && (seg_by == seg_ay);
  end

  // stage 2: products
  logic signed [PRW-1:0] p_sxly_r, p_sylx_r, p_dxly_r, p_dylx_r, p_sxdy_r, p_sydx_r;
  logic signed [PRW-1:0] p_dxdx_r, p_dydy_r;
  logic                  dz2_r, lz2_r, v2_r;

  always_ff @(posedge clk) begin
    p_sxly_r <= PRW'(sx_r) * PRW'(ly_r);
    p_sylx_r <= PRW'(sy_r) * PRW'(lx_r);
    p_dxly_r <= PRW'(dx_r) * PRW'(ly_r);
    p_dylx_r <= PRW'(dy_r) * PRW'(lx_r);
    p_sxdy_r <= PRW'(sx_r) * PRW'(dy_r);
    p_sydx_r <= PRW'(sy_r) * PRW'(dx_r);
    p_dxdx_r <= PRW'(dx_r) * PRW'(dx_r);
    p_dydy_r <= PRW'(dy_r) * PRW'(dy_r);
    dz2_r    <= dz1_r;
    lz2_r    <= lz1_r;
  end

  // stage 3: cross products and squared direction length
  logic signed [XW-1:0] cs_r, cd_r, e_r;
  logic [NDW-1:0]       nd3_r;
  logic                 dz3_r, lz3_r, v3_r;

  always_ff @(posedge clk) begin
    cs_r  <= XW'(p_sxly_r) - XW'(p_sylx_r);
    cd_r  <= XW'(p_dxly_r) - XW'(p_dylx_r);
    e_r   <= XW'(p_sxdy_r) - XW'(p_sydx_r);
    nd3_r <= NDW'(p_dxdx_r) + NDW'(p_dydy_r);
    dz3_r <= dz2_r;
    lz3_r <= lz2_r;
  end

  // stage 4: classification and magnitudes
  logic [MW-1:0] cs_mag, cd_mag, e_mag;
  reason_t       rsn;

  assign cs_mag = cs_r[XW-1] ? MW'(-cs_r) : MW'(cs_r);
  assign cd_mag = cd_r[XW-1] ? MW'(-cd_r) : MW'(cd_r);
  assign e_mag  = e_r[XW-1]  ? MW'(-e_r)  : MW'(e_r);

  always_comb begin
    if (dz3_r || lz3_r) begin
      rsn = RSN_DEGEN;
    end else if (cd_r == '0) begin
      rsn = RSN_PARALLEL;
    end else if ((cs_r != '0) && (cs_r[XW-1] == cd_r[XW-1])) begin
      rsn = RSN_BEHIND;
    end else if (((e_r != '0) && (e_r[XW-1] == cd_r[XW-1])) || (e_mag > cd_mag)) begin
      rsn = RSN_OUTSIDE;
    end else begin
      rsn = RSN_HIT;
    end
  end

  logic v4_r;

  always_ff @(posedge clk) begin
    reason_o <= rsn;
    cs_mag_o <= cs_mag;
    cd_mag_o <= cd_mag;
    nd_o     <= nd3_r;
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign valid_o = v4_r;

endmodule

// ===== src/rsi_fifo.sv =====
// Short queue between the front end and the back end.
`include "assert_macros.svh"
module rsi_fifo
  import rsi_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  count_r;
  logic             do_pop;

  assign do_pop  = pop_i && (count_r != '0);
  assign valid_o = (count_r != '0);
  assign data_o  = mem_r[rd_ptr_r];
  assign full_o  = (count_r == CNTW'(DEPTH));

  // storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNTW'(push_i) - CNTW'(do_pop);
    end
  end

  `RSI_NEVER(a_no_overflow, push_i && full_o && !do_pop, "queue overflow")
  `RSI_ASSERT(a_count_range, count_r <= CNTW'(DEPTH), "queue count out of range")
  `RSI_ASSERT(a_push_seen, (push_i && (count_r == '0)) |=> valid_o, "pushed entry lost")

endmodule

// ===== src/rsi_back.sv =====
// Back end: squares, product and digit-by-digit distance extraction.
module rsi_back
  import rsi_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DFLT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  reason_t            reason_i,
  input  logic [2*CW+1:0]    cs_mag_i,
  input  logic [2*CW+1:0]    cd_mag_i,
  input  logic [2*CW-1:0]    nd_i,
  output logic               valid_o,
  output logic               hit_o,
  output logic [DIST_W-1:0]  distance_o,
  output reason_t            reason_o
);

  localparam int MW  = 2 * CW + 2;
  localparam int NDW = 2 * CW;
  localparam int SQW = 2 * MW;
  localparam int NW  = SQW + NDW;
  localparam int RW  = SQW + DIST_W;
  localparam int QB  = SQW + 2 * DIST_W + 2;
  localparam int LW  = ((NW > QB) ? NW : QB) + 1;

  // squares of the cross products
  logic             va, vb;
  logic [SQW-1:0]   cs2, cd2;
  logic [NDW-1:0]   nd_d;
  logic [REASON_W-1:0] rsn_d;

  rsi_mul #(.AW(MW), .BW(MW), .SW(NDW)) u_mul_cs (
    .clk(clk), .rst_n(rst_n), .valid_i(valid_i), .a_i(cs_mag_i), .b_i(cs_mag_i),
    .side_i(nd_i), .valid_o(va), .p_o(cs2), .side_o(nd_d)
  );

  rsi_mul #(.AW(MW), .BW(MW), .SW(REASON_W)) u_mul_cd (
    .clk(clk), .rst_n(rst_n), .valid_i(valid_i), .a_i(cd_mag_i), .b_i(cd_mag_i),
    .side_i(REASON_W'(reason_i)), .valid_o(vb), .p_o(cd2), .side_o(rsn_d)
  );

  // numerator cs^2 * |D|^2
  logic                    vn;
  logic [NW-1:0]           num;
  logic [SQW+REASON_W-1:0] side_n;

  rsi_mul #(.AW(SQW), .BW(NDW), .SW(SQW + REASON_W)) u_mul_num (
    .clk(clk), .rst_n(rst_n), .valid_i(va && vb), .a_i(cs2), .b_i(nd_d),
    .side_i({cd2, rsn_d}), .valid_o(vn), .p_o(num), .side_o(side_n)
  );

  // one distance bit per stage: largest d with (d*|cd|)^2 <= num
  logic [NW-1:0]      n_s   [DIST_W];
  logic [SQW-1:0]     c2_s  [DIST_W];
  logic [LW-1:0]      q2_s  [DIST_W];
  logic [RW-1:0]      r_s   [DIST_W];
  logic [DIST_W-1:0]  d_s   [DIST_W];
  logic [REASON_W-1:0] rs_s [DIST_W];
  logic               v_s   [DIST_W];

  for (genvar j = 0; j < DIST_W; j++) begin : g_root
    localparam int K = DIST_W - 1 - j;
    logic [NW-1:0]       n_in;
    logic [SQW-1:0]      c2_in;
    logic [LW-1:0]       q2_in, q2_c;
    logic [RW-1:0]       r_in;
    logic [DIST_W-1:0]   d_in;
    logic [REASON_W-1:0] rs_in;
    logic                v_in, take;

    if (j == 0) begin : g_first
      assign n_in  = num;
      assign c2_in = side_n[SQW+REASON_W-1:REASON_W];
      assign q2_in = '0;
      assign r_in  = '0;
      assign d_in  = '0;
      assign rs_in = side_n[REASON_W-1:0];
      assign v_in  = vn;
    end else begin : g_next
      assign n_in  = n_s[j-1];
      assign c2_in = c2_s[j-1];
      assign q2_in = q2_s[j-1];
      assign r_in  = r_s[j-1];
      assign d_in  = d_s[j-1];
      assign rs_in = rs_s[j-1];
      assign v_in  = v_s[j-1];
    end

    // (Q + c*2^K)^2 = Q^2 + Q*c*2^(K+1) + c^2*2^(2K)
    assign q2_c = q2_in + (LW'(r_in) << (K + 1)) + (LW'(c2_in) << (2 * K));
    assign take = (q2_c <= LW'(n_in));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s[j] <= 1'b0;
      end else begin
        v_s[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      n_s[j]  <= n_in;
      c2_s[j] <= c2_in;
      rs_s[j] <= rs_in;
      q2_s[j] <= take ? q2_c : q2_in;
      r_s[j]  <= take ? (r_in + (RW'(c2_in) << K)) : r_in;
      d_s[j]  <= d_in | (DIST_W'(take) << K);
    end
  end

  // result formatting
  assign valid_o    = v_s[DIST_W-1];
  assign reason_o   = reason_t'(rs_s[DIST_W-1]);
  assign hit_o      = (reason_o == RSN_HIT);
  assign distance_o = hit_o ? d_s[DIST_W-1] : DIST_MAX;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the ray-segment intersection block.
module tb_top
  import rsi_pkg::*;
();

  localparam int CW = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS = 280;

  typedef struct {
    logic signed [CW-1:0] start_x, start_y, dir_x, dir_y;
    logic signed [CW-1:0] seg_ax, seg_ay, seg_bx, seg_by;
  } geom_t;

  typedef struct {
    logic              hit;
    logic [DIST_W-1:0] distance;
    reason_t           reason;
  } crossing_t;

  // Expected crossings in order, plus the exact fixed-point predictor
  class crossing_board;
    crossing_t pending[$];
    int errors = 0;

    static function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    static function logic [71:0] mag(logic signed [71:0] v);
      return v < 0 ? -v : v;
    endfunction

    static function crossing_t predict_crossing(geom_t g);
      logic signed [71:0] sx, sy, dx, dy, lx, ly, cs, cd, ev;
      logic [255:0] num, den, q;
      logic [71:0] nd;
      crossing_t r;
      sx = g.start_x; sx = sx - g.seg_ax;
      sy = g.start_y; sy = sy - g.seg_ay;
      lx = g.seg_bx;  lx = lx - g.seg_ax;
      ly = g.seg_by;  ly = ly - g.seg_ay;
      dx = g.dir_x;
      dy = g.dir_y;
      cs = sx * ly - sy * lx;
      cd = dx * ly - dy * lx;
      ev = sx * dy - sy * dx;
      r.hit = 1'b0;
      r.distance = DIST_MAX;
      if ((dx == 0 && dy == 0) || (lx == 0 && ly == 0)) r.reason = RSN_DEGEN;
      else if (cd == 0) r.reason = RSN_PARALLEL;
      else if (cs != 0 && ((cs < 0) == (cd < 0))) r.reason = RSN_BEHIND;
      else if ((ev != 0 && ((ev < 0) == (cd < 0))) || mag(ev) > mag(cd))
        r.reason = RSN_OUTSIDE;
      else begin
        r.reason = RSN_HIT;
        r.hit = 1'b1;
        nd = dx * dx + dy * dy;
        num = 256'(mag(cs)) * 256'(mag(cs)) * 256'(nd);
        den = 256'(mag(cd)) * 256'(mag(cd));
        q = num / den;
        if (q >= (256'd1 << 62)) r.distance = DIST_MAX;
        else r.distance = DIST_W'(isqrt(q[63:0]));
      end
      return r;
    endfunction

    function void note_ray(geom_t g);
      pending.insert(pending.size(), predict_crossing(g));
    endfunction

    function void check_crossing(crossing_t got);
      crossing_t exp_c;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0d dist=%0d reason=%0d",
                 $time, got.hit, got.distance, got.reason);
        errors++;
        return;
      end
      exp_c = pending[0];
      pending.delete(0);
      if (got.hit !== exp_c.hit) begin
        $display("%0t: hit mismatch exp %0d got %0d", $time, exp_c.hit, got.hit);
        errors++;
      end
      if (got.distance !== exp_c.distance) begin
        $display("%0t: distance mismatch exp %0d got %0d",
                 $time, exp_c.distance, got.distance);
        errors++;
      end
      if (got.reason !== exp_c.reason) begin
        $display("%0t: miss_reason mismatch exp %0d got %0d",
                 $time, exp_c.reason, got.reason);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy, out_valid, out_hit;
  logic [DIST_W-1:0] out_distance;
  logic [REASON_W-1:0] out_miss_reason;
  geom_t ray = '{default: '0};
  crossing_board board = new();
  int cycles = 0;

  always #5 clk = ~clk;

  ray_segment_intersect #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(ray.start_x), .in_start_y(ray.start_y),
    .in_dir_x(ray.dir_x), .in_dir_y(ray.dir_y),
    .in_seg_ax(ray.seg_ax), .in_seg_ay(ray.seg_ay),
    .in_seg_bx(ray.seg_bx), .in_seg_by(ray.seg_by),
    .out_valid(out_valid), .out_hit(out_hit),
    .out_distance(out_distance), .out_miss_reason(out_miss_reason)
  );

  // Monitor: note accepted rays, check strobed results
  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note_ray(ray);
    if (rst_n && out_valid)
      board.check_crossing('{out_hit, out_distance, reason_t'(out_miss_reason)});
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Drive one transaction and hold it until accepted; busy is stable at negedge
  task automatic send_ray(geom_t g);
    start <= 1'b1;
    ray <= g;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic geom_t mk(longint a, b, c, d, e, f, g, h);
    geom_t r;
    r.start_x = CW'(a); r.start_y = CW'(b); r.dir_x = CW'(c); r.dir_y = CW'(d);
    r.seg_ax = CW'(e); r.seg_ay = CW'(f); r.seg_bx = CW'(g); r.seg_by = CW'(h);
    return r;
  endfunction

  function automatic longint rnd_coord(int span_bits);
    return longint'($urandom_range(0, (1 << span_bits) - 1)) - (longint'(1) << (span_bits - 1));
  endfunction

  // Random ray: mostly constructed crossings, plus behind, parallel and noise
  function automatic geom_t random_ray();
    longint ax, ay, bx, by, px, py, sx, sy, t, k;
    int kind;
    geom_t r;
    kind = $urandom_range(0, 9);
    ax = rnd_coord(22); ay = rnd_coord(22);
    bx = rnd_coord(22); by = rnd_coord(22);
    sx = rnd_coord(22); sy = rnd_coord(22);
    t = $urandom_range(0, 1024);
    px = ax + (((bx - ax) * t) >>> 10);
    py = ay + (((by - ay) * t) >>> 10);
    k = $urandom_range(1, 3);
    case (kind)
      7: r = mk($urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
      8: r = mk(sx, sy, (bx - ax) * k, (by - ay) * k, ax, ay, bx, by);
      9: r = mk(rnd_coord(9), rnd_coord(9), rnd_coord(9), rnd_coord(9),
                rnd_coord(9), rnd_coord(9), rnd_coord(9), rnd_coord(9));
      6: r = mk(sx, sy, sx - px, sy - py, ax, ay, bx, by);
      default: r = mk(sx, sy, (px - sx) * k, (py - sy) * k, ax, ay, bx, by);
    endcase
    return r;
  endfunction

  task automatic random_phase(int n, int gap_pct);
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(0, 99) < gap_pct) idle_cycle();
      send_ray(random_ray());
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    geom_t directed[$];
    longint mx, mn;
    mx = 64'sh7FFFFFFF;
    mn = -64'sh80000000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: degenerate, parallel, collinear, behind, outside, edge hits
    directed = '{
      mk(0, 0, 0, 0, 65536, -65536, 65536, 65536),
      mk(0, 0, 65536, 0, 65536, 5, 65536, 5),
      mk(0, 0, 65536, 0, 0, 65536, 131072, 65536),
      mk(0, 0, 65536, 0, 65536, 0, 131072, 0),
      mk(0, 0, -65536, 0, 65536, -65536, 65536, 65536),
      mk(0, 0, 65536, 0, 65536, 65536, 65536, 131072),
      mk(0, 0, 65536, 0, 65536, -65536, 65536, 65536),
      mk(0, 0, 3, 4, 0, -65536, 0, 65536),
      mk(0, 0, 65536, 65536, 65536, 65536, 131072, 0),
      mk(0, 0, 65536, 0, 196608, 0, 196608, 65536),
      mk(mn, 0, 1, 0, mx, -5, mx, 5),
      mk(mn, mn, mx, mx, mx, mn, mn, mx),
      mk(mx, mx, mn, mn, mn, mx, mx, mn),
      mk(mn, mx, mx, mn, mn, mn, mx, mx),
      mk(mx, mn, mn, mx, mx, mx, mn, mn),
      mk(-1, -1, -1, -1, -1, -1, -1, -1),
      mk(0, 0, 1, 1, 1, 0, 0, 1),
      mk(0, 0, mx, 1, 100, mn, 100, mx),
      mk(0, 0, -65536, -65536, mn, 0, 0, mn)
    };
    foreach (directed[i]) send_ray(directed[i]);

    // Pause until every expected result has arrived
    wait_drained();

    random_phase(PHASE_ITEMS, 18);
    random_phase(PHASE_ITEMS, 76);
    random_phase(PHASE_ITEMS, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end
endmodule
